FILE: hdl/bpc_pkg.sv
// ----------------------------------------------------------------------------
// bpc_pkg
// Shared types and constants of the button press classifier.
// ----------------------------------------------------------------------------
package bpc_pkg;

    localparam int CNT_W     = 16;
    localparam int EV_W      = 3;
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 2;

    // remainder unit: bits retired per cycle and steps per division
    localparam int DIV_BITS  = 4;
    localparam int DIV_STEPS = CNT_W / DIV_BITS;
    localparam int STEP_W    = $clog2(DIV_STEPS);

    localparam logic [EV_W-1:0] EV_CLICK_DOWN = 3'd0;
    localparam logic [EV_W-1:0] EV_HOLD_START = 3'd1;
    localparam logic [EV_W-1:0] EV_HOLD_CYCLE = 3'd2;
    localparam logic [EV_W-1:0] EV_CLICK_UP   = 3'd3;
    localparam logic [EV_W-1:0] EV_HOLD_UP    = 3'd4;

    localparam logic [CFG_IDX_W-1:0] REG_PRESS_LEVEL = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DOWN_TICKS  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HOLD_TICKS  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CYCLE_TICKS = 2'd3;

    localparam logic             RST_PRESS_LEVEL = 1'b0;
    localparam logic [CNT_W-1:0] RST_DOWN_TICKS  = 16'd2;
    localparam logic [CNT_W-1:0] RST_HOLD_TICKS  = 16'd100;
    localparam logic [CNT_W-1:0] RST_CYCLE_TICKS = 16'd10;

    typedef struct packed {
        logic accept;
        logic div_step;
        logic load_out;
    } bpc_cmd_t;

    typedef struct packed {
        logic need_div;
        logic report;
        logic out_free;
    } bpc_status_t;

endpackage

FILE: hdl/bpc_in_if.sv
// ----------------------------------------------------------------------------
// bpc_in_if
// Request channel carrying one scan tick of the button pin.
// ----------------------------------------------------------------------------
interface bpc_in_if;
    logic valid;
    logic ready;
    logic pin_level;

    modport source (output valid, output pin_level, input ready);
    modport sink   (input valid, input pin_level, output ready);
endinterface

FILE: hdl/bpc_out_if.sv
// ----------------------------------------------------------------------------
// bpc_out_if
// Request channel carrying one classified button event.
// ----------------------------------------------------------------------------
interface bpc_out_if;
    logic                     valid;
    logic                     ready;
    logic [bpc_pkg::EV_W-1:0] event_code;

    modport source (output valid, output event_code, input ready);
    modport sink   (input valid, input event_code, output ready);
endinterface

FILE: hdl/button_press_classifier.sv
// ----------------------------------------------------------------------------
// button_press_classifier
// Click-down, hold, hold-cycle, click-up and hold-up detection for one button.
// ----------------------------------------------------------------------------
// One request on pin_in is one scan tick, and the next is taken only once the
// last is done. A pressed tick above the hold threshold with a nonzero period
// also runs the remainder unit, which retires 4 count bits per cycle.
// An event waits in an output register, so the next tick is taken while it is
// still pending; a new event stalls only if the previous one is not yet taken.
// Write configuration only while idle.
module button_press_classifier
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [bpc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [bpc_pkg::CFG_W-1:0]        cfg_data,
    bpc_in_if.sink                           pin_in,
    bpc_out_if.source                        event_out
);

    bpc_pkg::bpc_cmd_t    cmd;
    bpc_pkg::bpc_status_t status;

    bpc_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (pin_in.valid),
        .in_ready (pin_in.ready),
        .status   (status),
        .cmd      (cmd)
    );

    bpc_datapath u_datapath
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .pin_level  (pin_in.pin_level),
        .out_ready  (event_out.ready),
        .out_valid  (event_out.valid),
        .event_code (event_out.event_code),
        .cmd        (cmd),
        .status     (status)
    );

endmodule

FILE: hdl/bpc_datapath.sv
// ----------------------------------------------------------------------------
// bpc_datapath
// Config registers, press counter, classifier, remainder unit, output register.
// ----------------------------------------------------------------------------
module bpc_datapath
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [bpc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [bpc_pkg::CFG_W-1:0]       cfg_data,
    input  logic                            pin_level,
    input  logic                            out_ready,
    output logic                            out_valid,
    output logic [bpc_pkg::EV_W-1:0]        event_code,
    input  bpc_pkg::bpc_cmd_t               cmd,
    output bpc_pkg::bpc_status_t            status
);

    localparam int W = bpc_pkg::CNT_W;

    logic             press_level_reg;
    logic [W-1:0]     down_ticks_reg;
    logic [W-1:0]     hold_ticks_reg;
    logic [W-1:0]     cycle_ticks_reg;
    logic [W-1:0]     count_reg;
    logic [W-1:0]     count_next;
    logic [W-1:0]     rem_reg;
    logic [W-1:0]     rem_next;
    logic [W-1:0]     dvd_reg;
    logic [W-1:0]     dvd_next;
    logic [bpc_pkg::EV_W-1:0] ev_reg;
    logic [bpc_pkg::EV_W-1:0] ev_next;
    logic             rep_reg;
    logic             rep_next;
    logic             cyc_reg;
    logic             cyc_next;
    logic             out_valid_reg;
    logic [bpc_pkg::EV_W-1:0] out_ev_reg;
    logic [W:0]       trial;
    logic             pressed;

    // classification of the accepted tick
    always_comb
    begin
        pressed  = (pin_level == press_level_reg);
        count_next = count_reg + W'(1);
        ev_next  = bpc_pkg::EV_HOLD_CYCLE;
        rep_next = 1'b0;
        cyc_next = 1'b0;
        if (pressed)
        begin
            if (count_next == down_ticks_reg)
            begin
                ev_next  = bpc_pkg::EV_CLICK_DOWN;
                rep_next = 1'b1;
            end
            else if (count_next == hold_ticks_reg)
            begin
                ev_next  = bpc_pkg::EV_HOLD_START;
                rep_next = 1'b1;
            end
            else if (count_next > hold_ticks_reg)
            begin
                cyc_next = (cycle_ticks_reg != '0);
            end
        end
        else
        begin
            count_next = '0;
            if (count_reg >= down_ticks_reg && count_reg < hold_ticks_reg)
            begin
                ev_next  = bpc_pkg::EV_CLICK_UP;
                rep_next = 1'b1;
            end
            else if (count_reg >= hold_ticks_reg)
            begin
                ev_next  = bpc_pkg::EV_HOLD_UP;
                rep_next = 1'b1;
            end
        end
    end

    // restoring remainder, DIV_BITS dividend bits per cycle
    always_comb
    begin
        rem_next = rem_reg;
        dvd_next = dvd_reg;
        trial    = '0;
        for (int i = 0; i < bpc_pkg::DIV_BITS; i++)
        begin
            trial    = {rem_next, dvd_next[W-1]};
            dvd_next = {dvd_next[W-2:0], 1'b0};
            if (trial >= {1'b0, cycle_ticks_reg})
            begin
                trial = trial - {1'b0, cycle_ticks_reg};
            end
            rem_next = trial[W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            press_level_reg <= bpc_pkg::RST_PRESS_LEVEL;
            down_ticks_reg  <= bpc_pkg::RST_DOWN_TICKS;
            hold_ticks_reg  <= bpc_pkg::RST_HOLD_TICKS;
            cycle_ticks_reg <= bpc_pkg::RST_CYCLE_TICKS;
            count_reg       <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    bpc_pkg::REG_PRESS_LEVEL: press_level_reg <= cfg_data[0];
                    bpc_pkg::REG_DOWN_TICKS:  down_ticks_reg  <= cfg_data[W-1:0];
                    bpc_pkg::REG_HOLD_TICKS:  hold_ticks_reg  <= cfg_data[W-1:0];
                    bpc_pkg::REG_CYCLE_TICKS: cycle_ticks_reg <= cfg_data[W-1:0];
                    default: ;
                endcase
            end
            if (cmd.accept)
            begin
                count_reg <= count_next;
            end
            if (cmd.load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            ev_reg  <= ev_next;
            rep_reg <= rep_next;
            cyc_reg <= cyc_next;
            rem_reg <= '0;
            dvd_reg <= count_next;
        end
        else if (cmd.div_step)
        begin
            rem_reg <= rem_next;
            dvd_reg <= dvd_next;
        end
        if (cmd.load_out)
        begin
            out_ev_reg <= ev_reg;
        end
    end

    assign status.need_div = cyc_next;
    assign status.report   = rep_reg || (cyc_reg && rem_reg == '0);
    assign status.out_free = !out_valid_reg || out_ready;
    assign out_valid       = out_valid_reg;
    assign event_code      = out_ev_reg;

endmodule

FILE: hdl/bpc_ctrl.sv
// ----------------------------------------------------------------------------
// bpc_ctrl
// Sequencer: accept a tick, run the remainder unit if needed, hand off any event.
// ----------------------------------------------------------------------------
module bpc_ctrl
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  bpc_pkg::bpc_status_t  status,
    output bpc_pkg::bpc_cmd_t     cmd
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_DIV  = 2'd1;
    localparam logic [1:0] S_DONE = 2'd2;

    localparam logic [bpc_pkg::STEP_W-1:0] LAST_STEP =
        bpc_pkg::STEP_W'(bpc_pkg::DIV_STEPS - 1);

    logic [1:0]                  state_reg;
    logic [1:0]                  state_next;
    logic [bpc_pkg::STEP_W-1:0]  step_reg;
    logic [bpc_pkg::STEP_W-1:0]  step_next;

    always_comb
    begin
        state_next   = state_reg;
        step_next    = step_reg;
        in_ready     = 1'b0;
        cmd.accept   = 1'b0;
        cmd.div_step = 1'b0;
        cmd.load_out = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready  = 1'b1;
                step_next = '0;
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = status.need_div ? S_DIV : S_DONE;
                end
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                step_next    = step_reg + 1'b1;
                if (step_reg == LAST_STEP)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!status.report)
                begin
                    state_next = S_IDLE;
                end
                else if (status.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

endmodule

FILE: tb/button_press_classifier_test.sv
// ----------------------------------------------------------------------------
// button_press_classifier_test
// Self-checking bench for the button press classifier.
// ----------------------------------------------------------------------------
// Scan ticks go in on the pin request channel. A shadow model of the press
// counter turns every accepted tick into the event it should cause, if any.
// Events that come out are compared in order. Both channels idle in random
// bursts but for the last, steady phase, and one long receiver hold-off fills
// the block up. Register settings change between phases while the block is
// idle: directed event sequences, field extremes and random press sequences.
// ----------------------------------------------------------------------------
module button_press_classifier_test;

    logic                          clk;
    logic                          rst_n;
    logic                          cfg_we;
    logic [bpc_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [bpc_pkg::CFG_W-1:0]     cfg_data;

    bpc_in_if  pin_in ();
    bpc_out_if event_out ();

    button_press_classifier DUT
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .pin_in    (pin_in),
        .event_out (event_out)
    );

    // shadow of the block's registers and press count
    logic                      press_level_q;
    logic [bpc_pkg::CNT_W-1:0] down_ticks_q;
    logic [bpc_pkg::CNT_W-1:0] hold_ticks_q;
    logic [bpc_pkg::CNT_W-1:0] cycle_ticks_q;
    logic [bpc_pkg::CNT_W-1:0] press_count_q;

    logic [bpc_pkg::EV_W-1:0] pending_events[$];

    int unsigned mismatches;
    int unsigned ticks_sent;
    int unsigned events_checked;
    int unsigned settings_loaded;
    int unsigned event_tally[5];
    int unsigned hold_off_cycles;
    bit          tx_idle_on;
    bit          rx_idle_on;

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #1 clk = ~clk;
        end
    end

    initial
    begin
        #20000000;
        $display("FAILED: results differ");
        $finish;
    end

    task automatic report_mismatch(input string what,
                                   input logic [bpc_pkg::EV_W-1:0] got,
                                   input logic [bpc_pkg::EV_W-1:0] want);
        mismatches++;
        $display("mismatch @%0t: %s got %0d expected %0d", $time, what, got, want);
    endtask

    function automatic void note_event(input logic [bpc_pkg::EV_W-1:0] code);
        pending_events.push_back(code);
        event_tally[code]++;
    endfunction

    function automatic void classify_tick(input logic level);
        logic [bpc_pkg::CNT_W-1:0] held;
        if (level == press_level_q)
        begin
            press_count_q = press_count_q + 1'b1;
            if (press_count_q == down_ticks_q)
            begin
                note_event(bpc_pkg::EV_CLICK_DOWN);
            end
            else if (press_count_q == hold_ticks_q)
            begin
                note_event(bpc_pkg::EV_HOLD_START);
            end
            else if (press_count_q > hold_ticks_q && cycle_ticks_q != '0
                     && (press_count_q % cycle_ticks_q) == '0)
            begin
                note_event(bpc_pkg::EV_HOLD_CYCLE);
            end
        end
        else
        begin
            held = press_count_q;
            press_count_q = '0;
            if (held >= down_ticks_q && held < hold_ticks_q)
            begin
                note_event(bpc_pkg::EV_CLICK_UP);
            end
            else if (held >= hold_ticks_q)
            begin
                note_event(bpc_pkg::EV_HOLD_UP);
            end
        end
    endfunction

    // event checker
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (rst_n && event_out.valid && event_out.ready)
            begin
                events_checked++;
                if (pending_events.size() == 0)
                begin
                    report_mismatch("unexpected event_code", event_out.event_code, '0);
                end
                else if (event_out.event_code != pending_events[0])
                begin
                    report_mismatch("event_code", event_out.event_code, pending_events[0]);
                    void'(pending_events.pop_front());
                end
                else
                begin
                    void'(pending_events.pop_front());
                end
            end
        end
    end

    // event receiver
    initial
    begin
        event_out.ready <= 1'b0;
        @(posedge clk);
        while (!rst_n)
        begin
            @(posedge clk);
        end
        forever
        begin
            if (hold_off_cycles != 0)
            begin
                event_out.ready <= 1'b0;
                repeat (hold_off_cycles) @(posedge clk);
                hold_off_cycles = 0;
            end
            else if (rx_idle_on && $urandom_range(0, 3) == 0)
            begin
                event_out.ready <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge clk);
            end
            else
            begin
                event_out.ready <= 1'b1;
                repeat ($urandom_range(1, 8)) @(posedge clk);
            end
        end
    end

    task automatic send_tick(input logic level);
        if (tx_idle_on && $urandom_range(0, 3) == 0)
        begin
            pin_in.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        pin_in.valid     <= 1'b1;
        pin_in.pin_level <= level;
        @(posedge clk);
        while (!pin_in.ready)
        begin
            @(posedge clk);
        end
        classify_tick(level);
        ticks_sent++;
    endtask

    task automatic press_for(input int unsigned n);
        repeat (n) send_tick(press_level_q);
    endtask

    task automatic release_for(input int unsigned n);
        repeat (n) send_tick(~press_level_q);
    endtask

    task automatic wait_drained();
        pin_in.valid <= 1'b0;
        while (pending_events.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (10) @(posedge clk);
    endtask

    task automatic write_reg(input logic [bpc_pkg::CFG_IDX_W-1:0] idx,
                             input logic [bpc_pkg::CFG_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        case (idx)
            bpc_pkg::REG_PRESS_LEVEL: press_level_q = value[0];
            bpc_pkg::REG_DOWN_TICKS:  down_ticks_q  = value;
            bpc_pkg::REG_HOLD_TICKS:  hold_ticks_q  = value;
            bpc_pkg::REG_CYCLE_TICKS: cycle_ticks_q = value;
            default: ;
        endcase
    endtask

    task automatic load_settings(input logic level,
                                 input logic [bpc_pkg::CNT_W-1:0] down,
                                 input logic [bpc_pkg::CNT_W-1:0] hold,
                                 input logic [bpc_pkg::CNT_W-1:0] cycle);
        wait_drained();
        write_reg(bpc_pkg::REG_PRESS_LEVEL, {{(bpc_pkg::CFG_W-1){1'b0}}, level});
        write_reg(bpc_pkg::REG_DOWN_TICKS, down);
        write_reg(bpc_pkg::REG_HOLD_TICKS, hold);
        write_reg(bpc_pkg::REG_CYCLE_TICKS, cycle);
        cfg_we <= 1'b0;
        @(posedge clk);
        settings_loaded++;
    endtask

    task automatic test_reset_settings();
        release_for(2);
        press_for(3);
        release_for(1);
        press_for(1);
        release_for(1);
    endtask

    task automatic test_directed_events();
        // all five events plus a silent hold tick
        load_settings(1'b1, 16'd1, 16'd3, 16'd2);
        release_for(1);
        press_for(6);
        release_for(1);
        press_for(2);
        release_for(1);
        // equal thresholds: click down wins over hold start
        load_settings(1'b0, 16'd2, 16'd2, 16'd3);
        press_for(4);
        release_for(1);
        // period zero: no hold cycle events
        load_settings(1'b0, 16'd1, 16'd2, 16'd0);
        press_for(5);
        release_for(1);
    endtask

    task automatic test_field_extremes();
        load_settings(1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        press_for(10);
        release_for(1);
        load_settings(1'b1, 16'd1, 16'd1, 16'd1);
        press_for(8);
        release_for(1);
        load_settings(1'b0, 16'd40, 16'd5, 16'd4);
        press_for(45);
        release_for(1);
    endtask

    task automatic test_output_backpressure();
        load_settings(1'b1, 16'd1, 16'd2, 16'd1);
        hold_off_cycles = 300;
        press_for(40);
        release_for(1);
        wait_drained();
    endtask

    task automatic random_settings();
        logic                      level;
        logic [bpc_pkg::CNT_W-1:0] down;
        logic [bpc_pkg::CNT_W-1:0] hold;
        logic [bpc_pkg::CNT_W-1:0] cycle;
        int unsigned mode;
        level = 1'($urandom_range(0, 1));
        mode  = $urandom_range(0, 9);
        down  = bpc_pkg::CNT_W'($urandom_range(1, 6));
        hold  = bpc_pkg::CNT_W'($urandom_range(1, 30));
        cycle = bpc_pkg::CNT_W'($urandom_range(0, 6));
        if (mode == 0)
        begin
            down  = bpc_pkg::CNT_W'($urandom_range(1, 16'hFFFF));
            hold  = bpc_pkg::CNT_W'($urandom_range(1, 16'hFFFF));
            cycle = bpc_pkg::CNT_W'($urandom_range(0, 16'hFFFF));
        end
        else if (mode == 1)
        begin
            hold = down;
        end
        else if (mode == 2)
        begin
            down = bpc_pkg::CNT_W'($urandom_range(8, 40));
        end
        load_settings(level, down, hold, cycle);
    endtask

    task automatic random_presses(input int unsigned count);
        int unsigned start;
        int unsigned span;
        start = ticks_sent;
        while (ticks_sent - start < count)
        begin
            if ($urandom_range(0, 6) == 0)
            begin
                repeat ($urandom_range(1, 5)) send_tick(1'($urandom_range(0, 1)));
            end
            else
            begin
                span = hold_ticks_q + 3 * cycle_ticks_q + 4;
                if (span > 80)
                begin
                    span = 80;
                end
                press_for($urandom_range(1, span));
                release_for($urandom_range(1, 3));
            end
        end
    endtask

    task automatic test_random_presses();
        repeat (8)
        begin
            random_settings();
            random_presses(130);
        end
    endtask

    task automatic test_steady_flow();
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        load_settings(1'b1, 16'd3, 16'd12, 16'd4);
        random_presses(200);
    endtask

    initial
    begin
        rst_n            <= 1'b0;
        cfg_we           <= 1'b0;
        cfg_index        <= '0;
        cfg_data         <= '0;
        pin_in.valid     <= 1'b0;
        pin_in.pin_level <= 1'b0;
        press_level_q    = bpc_pkg::RST_PRESS_LEVEL;
        down_ticks_q     = bpc_pkg::RST_DOWN_TICKS;
        hold_ticks_q     = bpc_pkg::RST_HOLD_TICKS;
        cycle_ticks_q    = bpc_pkg::RST_CYCLE_TICKS;
        press_count_q    = '0;
        hold_off_cycles  = 0;
        tx_idle_on       = 1'b1;
        rx_idle_on       = 1'b1;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_settings();
        test_directed_events();
        test_field_extremes();
        test_output_backpressure();
        test_random_presses();
        test_steady_flow();

        wait_drained();
        repeat (20) @(posedge clk);
        $display("covered %0d scan ticks over %0d register settings, %0d events checked",
                 ticks_sent, settings_loaded, events_checked);
        $display("events: click down %0d, hold start %0d, hold cycle %0d,",
                 event_tally[0], event_tally[1], event_tally[2]);
        $display("        click up %0d, hold up %0d", event_tally[3], event_tally[4]);
        if (mismatches == 0)
        begin
            $display("PASSED: all results match");
        end
        else
        begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
